FILE: hw/rtl/nsc_pkg.sv
`default_nettype none

package nsc_pkg;

   localparam int MAX_LENGTH = 80;
   localparam int COUNT_WIDTH = 7;
   localparam logic [COUNT_WIDTH-1:0] TOO_LONG_LIMIT = COUNT_WIDTH'(MAX_LENGTH + 3);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] PRINT_LOW = 8'h20;
   localparam logic [7:0] PRINT_HIGH = 8'h7E;

   typedef enum logic [2:0] {
      PH_DOLLAR,
      PH_BODY,
      PH_HEX_HI,
      PH_HEX_LO,
      PH_TRAIL,
      PH_CR,
      PH_DONE,
      PH_STOP
   } phase_type;

   typedef enum logic [2:0] {
      ERR_OK,
      ERR_TOO_LONG,
      ERR_NO_DOLLAR,
      ERR_BAD_HEX,
      ERR_MISMATCH,
      ERR_NO_SUM,
      ERR_TRAILER
   } err_type;

   // Bit 4 set means the character is not a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b0, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b0, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b0, 4'(b - 8'h57)};
      end else begin
         r = 5'h10;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nsc_channels.sv
`default_nettype none

interface nsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_end;

   modport source (output valid, output data_byte, output is_end, input ready);
   modport sink (input valid, input data_byte, input is_end, output ready);
endinterface

interface nsc_rsp_if;
   logic       valid;
   logic       ready;
   logic       valid_res;
   logic [2:0] error_code;
   logic [7:0] computed_sum;
   logic       had_checksum;

   modport source (output valid, output valid_res, output error_code,
                   output computed_sum, output had_checksum, input ready);
   modport sink (input valid, input valid_res, input error_code,
                 input computed_sum, input had_checksum, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nmea_sentence_check.sv
// Channel    Direction  Payload                                          Transfer
// req_chan   in         data_byte[7:0], is_end                           valid & ready
// rsp_chan   out        valid_res, error_code[2:0], computed_sum[7:0],   valid & ready
//                       had_checksum
// csr        in         csr_write_data (strict mode)                     csr_write_en
//
// One byte is taken per cycle, except that a byte that closes a sentence waits
// for a free result. A byte passes an input register, then the sentence state
// updates; an end item, as it leaves the input register, loads its verdict into
// the result register. Synchronous reset clears all sentence state and strict
// mode. A stalled result holds only end items and NUL bytes; plain bytes keep flowing while the result waits.
`default_nettype none

module nmea_sentence_check (
   input  wire logic      clock,
   input  wire logic      reset,
   nsc_req_if.sink        req_chan,
   nsc_rsp_if.source      rsp_chan,
   input  wire logic      csr_write_en,
   input  wire logic      csr_write_data
);

   logic                 strict_ff;
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_end_ff;

   nsc_pkg::phase_type   phase_ff, phase_in;
   nsc_pkg::err_type     error_ff, error_in;
   logic [7:0]           xor_ff, xor_in;
   logic [3:0]           nibble_ff, nibble_in;
   logic [nsc_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic                 seen_ff, seen_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 res_ok_ff;
   logic [2:0]           res_code_ff;
   logic [7:0]           res_sum_ff;
   logic                 res_seen_ff;

   logic                 close;
   logic                 advance;
   logic                 rsp_free;
   logic [4:0]           hex;
   nsc_pkg::err_type     verdict;

   assign close    = in_end_ff || (in_byte_ff == nsc_pkg::CHAR_NUL);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && (!close || rsp_free);
   assign req_chan.ready = !in_valid_ff || advance;
   assign hex = nsc_pkg::hex_digit(in_byte_ff);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
   end

   // Next sentence state.
   always_comb begin
      phase_in  = phase_ff;
      error_in  = error_ff;
      xor_in    = xor_ff;
      nibble_in = nibble_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      if (advance) begin
         if (close) begin
            phase_in  = nsc_pkg::PH_DOLLAR;
            error_in  = nsc_pkg::ERR_OK;
            xor_in    = '0;
            nibble_in = '0;
            count_in  = '0;
            seen_in   = 1'b0;
         end else begin
            if (count_ff != nsc_pkg::COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            unique case (phase_ff)
               nsc_pkg::PH_DOLLAR: begin
                  if (in_byte_ff == nsc_pkg::CHAR_DOLLAR) begin
                     phase_in = nsc_pkg::PH_BODY;
                  end else begin
                     phase_in = nsc_pkg::PH_STOP;
                     error_in = nsc_pkg::ERR_NO_DOLLAR;
                  end
               end
               nsc_pkg::PH_BODY: begin
                  if (in_byte_ff == nsc_pkg::CHAR_STAR) begin
                     seen_in  = 1'b1;
                     phase_in = nsc_pkg::PH_HEX_HI;
                  end else if (in_byte_ff >= nsc_pkg::PRINT_LOW &&
                               in_byte_ff <= nsc_pkg::PRINT_HIGH) begin
                     xor_in = xor_ff ^ in_byte_ff;
                  end else if (strict_ff) begin
                     phase_in = nsc_pkg::PH_STOP;
                     error_in = nsc_pkg::ERR_NO_SUM;
                  end else if (in_byte_ff == nsc_pkg::CHAR_LF) begin
                     phase_in = nsc_pkg::PH_DONE;
                  end else if (in_byte_ff == nsc_pkg::CHAR_CR) begin
                     phase_in = nsc_pkg::PH_CR;
                  end else begin
                     phase_in = nsc_pkg::PH_STOP;
                     error_in = nsc_pkg::ERR_TRAILER;
                  end
               end
               nsc_pkg::PH_HEX_HI: begin
                  if (hex[4]) begin
                     phase_in = nsc_pkg::PH_STOP;
                     error_in = nsc_pkg::ERR_BAD_HEX;
                  end else begin
                     nibble_in = hex[3:0];
                     phase_in  = nsc_pkg::PH_HEX_LO;
                  end
               end
               nsc_pkg::PH_HEX_LO: begin
                  if (hex[4]) begin
                     phase_in = nsc_pkg::PH_STOP;
                     error_in = nsc_pkg::ERR_BAD_HEX;
                  end else if ({nibble_ff, hex[3:0]} != xor_ff) begin
                     phase_in = nsc_pkg::PH_STOP;
                     error_in = nsc_pkg::ERR_MISMATCH;
                  end else begin
                     phase_in = nsc_pkg::PH_TRAIL;
                  end
               end
               nsc_pkg::PH_TRAIL: begin
                  if (in_byte_ff == nsc_pkg::CHAR_LF) begin
                     phase_in = nsc_pkg::PH_DONE;
                  end else if (in_byte_ff == nsc_pkg::CHAR_CR) begin
                     phase_in = nsc_pkg::PH_CR;
                  end else begin
                     phase_in = nsc_pkg::PH_STOP;
                     error_in = nsc_pkg::ERR_TRAILER;
                  end
               end
               nsc_pkg::PH_CR: begin
                  if (in_byte_ff == nsc_pkg::CHAR_LF) begin
                     phase_in = nsc_pkg::PH_DONE;
                  end else begin
                     phase_in = nsc_pkg::PH_STOP;
                     error_in = nsc_pkg::ERR_TRAILER;
                  end
               end
               nsc_pkg::PH_DONE: begin
                  phase_in = nsc_pkg::PH_STOP;
                  error_in = nsc_pkg::ERR_TRAILER;
               end
               nsc_pkg::PH_STOP: begin
                  phase_in = nsc_pkg::PH_STOP;
               end
               default: begin
                  phase_in = nsc_pkg::PH_STOP;
               end
            endcase
         end
      end
   end

   // Verdict for the sentence as it stands; too_long overrides everything.
   always_comb begin
      verdict = error_ff;
      if (error_ff == nsc_pkg::ERR_OK) begin
         unique case (phase_ff)
            nsc_pkg::PH_DOLLAR: verdict = nsc_pkg::ERR_NO_DOLLAR;
            nsc_pkg::PH_BODY:   verdict = strict_ff ? nsc_pkg::ERR_NO_SUM : nsc_pkg::ERR_OK;
            nsc_pkg::PH_HEX_HI,
            nsc_pkg::PH_HEX_LO: verdict = nsc_pkg::ERR_BAD_HEX;
            nsc_pkg::PH_CR:     verdict = nsc_pkg::ERR_TRAILER;
            default:            verdict = nsc_pkg::ERR_OK;
         endcase
      end
      if (count_ff > nsc_pkg::TOO_LONG_LIMIT) begin
         verdict = nsc_pkg::ERR_TOO_LONG;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_free) begin
         rsp_valid_in = advance && close;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         phase_ff     <= nsc_pkg::PH_DOLLAR;
         error_ff     <= nsc_pkg::ERR_OK;
         xor_ff       <= '0;
         nibble_ff    <= '0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            strict_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         error_ff     <= error_in;
         xor_ff       <= xor_in;
         nibble_ff    <= nibble_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_end_ff  <= req_chan.is_end;
      end
      if (advance && close) begin
         res_ok_ff   <= (verdict == nsc_pkg::ERR_OK);
         res_code_ff <= verdict;
         res_sum_ff  <= xor_ff;
         res_seen_ff <= seen_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.valid_res    = res_ok_ff;
   assign rsp_chan.error_code   = res_code_ff;
   assign rsp_chan.computed_sum = res_sum_ff;
   assign rsp_chan.had_checksum = res_seen_ff;

endmodule

`default_nettype wire
